// ----- rtl/akst_pkg.sv -----
`default_nettype none

package akst_pkg;

   // Fixed field widths of the two channels.
   localparam int KEY_W     = 64;
   localparam int POS_W     = 6;
   localparam int CNT_OUT_W = 7;
   localparam int BYTE_BITS = 8;

   // Command codes.
   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key_in;
      logic [POS_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 found;
      logic [KEY_W-1:0]     key_out;
      logic [CNT_OUT_W-1:0] key_count;
   } rsp_type;

   // Strobes from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic search;
      logic shift;
      logic apply;
      logic rd_issue;
      logic rd_capture;
      logic rsp_load;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic [1:0] cmd;
      logic       search_end;
      logic       hit;
      logic       shift_end;
      logic       rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/access_key_set_table.sv -----
`default_nettype none

// Channel  Direction  Handshake            Item
// req      in         req_valid/req_ready  req_type: cmd, key_in, position
// rsp      out        rsp_valid/rsp_ready  rsp_type: status, found, key_out, key_count
//
// One item at a time. Insert, lookup and remove scan the entries until a hit
// or the end; a remove that hits then shifts the later entries down, and a read
// goes straight to the store. The next item is taken once the result is loaded.
// Time is set by the single key store, one entry a cycle to search and shift.
// Reset clears the key count, the controller state and the result valid flag.
// A new item is taken while a result waits; its result then waits for rsp_ready.

module access_key_set_table #(
   parameter int MAX_KEYS  = 64,
   parameter int KEY_BYTES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire akst_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output akst_pkg::rsp_type      rsp_data
);

   import akst_pkg::*;

   dp_cmd_type  ctrl;
   dp_stat_type stat;

   akst_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   akst_datapath #(
      .MAX_KEYS  (MAX_KEYS),
      .KEY_BYTES (KEY_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/akst_ram.sv -----
`default_nettype none

module akst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/akst_datapath.sv -----
`default_nettype none

module akst_datapath #(
   parameter int MAX_KEYS  = 64,
   parameter int KEY_BYTES = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire akst_pkg::req_type    req_data,
   input  wire akst_pkg::dp_cmd_type ctrl,
   output akst_pkg::dp_stat_type     stat,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output akst_pkg::rsp_type         rsp_data
);

   import akst_pkg::*;

   localparam int KW = BYTE_BITS * KEY_BYTES;
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_KEYS);

   logic [1:0]       cmd_ff, cmd_in;
   logic [KW-1:0]    key_ff, key_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    addr_ff, addr_in;
   logic             chk_ff, chk_in;
   logic [CW-1:0]    chk_addr_ff, chk_addr_in;
   logic             found_ff, found_in;
   logic [1:0]       status_ff, status_in;
   logic [KW-1:0]    kout_ff, kout_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [KW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [KW-1:0] ram_rd_data;

   logic          hit;
   logic          scan_more;
   logic          full;
   logic          bad;
   logic          ins_ok;
   logic [AW-1:0] rd_idx;

   // Compare of the entry read last cycle, and the checks on the count.
   always_comb begin
      hit       = chk_ff && (ram_rd_data == key_ff);
      scan_more = addr_ff < count_ff;
      full      = count_ff == MaxCount;
      bad       = PW'(pos_ff) >= PW'(count_ff);
      ins_ok    = (cmd_ff == CMD_INSERT) && !found_ff && !full;
      rd_idx    = AW'(PW'(count_ff) - PW'(1) - PW'(pos_ff));
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.search_end = hit || !scan_more;
      stat.hit        = hit;
      stat.shift_end  = !scan_more;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Store ports: the scan pointer or a read's index reads, a shift or an insert writes.
   always_comb begin
      if (ctrl.rd_issue) begin
         ram_rd_addr = rd_idx;
      end else if (scan_more) begin
         ram_rd_addr = AW'(addr_ff);
      end else begin
         ram_rd_addr = '0;
      end
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(count_ff);
      ram_wr_data = key_ff;
      if (ctrl.shift && chk_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = AW'(chk_addr_ff - CW'(1));
         ram_wr_data = ram_rd_data;
      end else if (ctrl.apply && ins_ok) begin
         ram_wr_en = 1'b1;
      end
   end

   akst_ram #(
      .WIDTH(KW),
      .DEPTH(MAX_KEYS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next values of the working registers.
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      chk_in       = chk_ff;
      chk_addr_in  = chk_addr_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      kout_in      = kout_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (ctrl.load) begin
         cmd_in    = req_data.cmd;
         key_in    = req_data.key_in[KEY_W-1 -: KW];
         pos_in    = req_data.position;
         addr_in   = '0;
         chk_in    = 1'b0;
         found_in  = 1'b0;
         status_in = ST_OK;
         kout_in   = '0;
      end

      // Linear search: one read issued and one compare made per cycle.
      // On a hit the pointer moves to the entry after it, ready for a shift.
      if (ctrl.search) begin
         if (hit || !scan_more) begin
            found_in = hit;
            addr_in  = chk_addr_ff + CW'(1);
            chk_in   = 1'b0;
         end else begin
            chk_in      = 1'b1;
            chk_addr_in = addr_ff;
            addr_in     = addr_ff + CW'(1);
         end
      end

      // Compacting shift: read entry i, write it to i-1 the cycle after.
      if (ctrl.shift) begin
         chk_in      = scan_more;
         chk_addr_in = addr_ff;
         if (scan_more) begin
            addr_in = addr_ff + CW'(1);
         end
      end

      if (ctrl.apply) begin
         if (ins_ok) begin
            count_in = count_ff + CW'(1);
         end else if ((cmd_ff == CMD_REMOVE) && found_ff) begin
            count_in = count_ff - CW'(1);
         end else if ((cmd_ff == CMD_INSERT) && !found_ff) begin
            status_in = ST_FULL;
         end
      end

      if (ctrl.rd_issue && bad) begin
         status_in = ST_BAD;
      end

      if (ctrl.rd_capture) begin
         kout_in = (status_ff == ST_BAD) ? '0 : ram_rd_data;
      end

      // Output register: a new result may be loaded as the old one leaves.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.status    = status_ff;
         rsp_in.found     = found_ff;
         rsp_in.key_out   = KEY_W'(kout_ff) << (KEY_W - KW);
         rsp_in.key_count = CNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      addr_ff     <= addr_in;
      chk_addr_ff <= chk_addr_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      kout_ff     <= kout_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/akst_controller.sv -----
`default_nettype none

module akst_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire akst_pkg::dp_stat_type stat,
   output akst_pkg::dp_cmd_type       ctrl
);

   import akst_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_APPLY  = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_RCAP   = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;

   // Sequencing of one item and the strobes for each step.
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_SEARCH;
            end
         end
         S_SEARCH: begin
            ctrl.search = 1'b1;
            if (stat.search_end) begin
               unique case (stat.cmd)
                  CMD_INSERT: state_in = S_APPLY;
                  CMD_REMOVE: state_in = stat.hit ? S_SHIFT : S_RESP;
                  default:    state_in = S_RESP;
               endcase
            end
            if (stat.cmd == CMD_READ) begin
               ctrl.search = 1'b0;
               state_in    = S_READ;
            end
         end
         S_SHIFT: begin
            ctrl.shift = 1'b1;
            if (stat.shift_end) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            ctrl.apply = 1'b1;
            state_in   = S_RESP;
         end
         S_READ: begin
            ctrl.rd_issue = 1'b1;
            state_in      = S_RCAP;
         end
         S_RCAP: begin
            ctrl.rd_capture = 1'b1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               ctrl.rsp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

`default_nettype wire

// ----- rtl/akst_checker.sv -----
`default_nettype none

module akst_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire akst_pkg::rsp_type rsp_data
);

   import akst_pkg::*;

   // The block comes out of reset ready for an item.
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("not ready after reset");

   // Items are handled one at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again in the cycle after an accepted item");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed or dropped while stalled");

   // A failed command never reports a key or a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |->
      (!rsp_data.found && (rsp_data.key_out == '0)))
      else $error("failed command reports a key or a hit");

   // A hit comes only from a search, which returns no key and succeeds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |->
      ((rsp_data.key_out == '0) && (rsp_data.status == ST_OK)))
      else $error("hit reported with a key or a failure");

endmodule

bind access_key_set_table akst_checker u_akst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none

module tb_top;
   import akst_pkg::*;

   localparam int MAX_KEYS     = 64;
   localparam int KEY_BYTES    = 8;
   localparam int POOL_SIZE    = 96;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE_WAIT  = 2 * MAX_KEYS + 16;
   localparam logic [KEY_W-1:0] KEY_MASK =
      ~((64'd1 << (KEY_W - BYTE_BITS * KEY_BYTES)) - 64'd1);

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Own copy of the table contents, oldest entry at index 0.
   logic [KEY_W-1:0] held_keys [MAX_KEYS];
   int               held_count = 0;
   logic [KEY_W-1:0] key_pool  [POOL_SIZE];
   rsp_type          predicted_rsp [$];
   int               failures    = 0;
   int               cycle_count = 0;
   logic             no_idle     = 1'b0;

   access_key_set_table #(
      .MAX_KEYS  (MAX_KEYS),
      .KEY_BYTES (KEY_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Work out the reply to one command and update the table copy.
   function automatic rsp_type predict_table(req_type item);
      rsp_type          r;
      logic [KEY_W-1:0] k;
      int               hit;
      r   = '0;
      k   = item.key_in & KEY_MASK;
      hit = -1;
      for (int i = 0; i < held_count; i++) begin
         if (hit < 0 && held_keys[i] == k) hit = i;
      end
      case (item.cmd)
         CMD_INSERT: begin
            if (hit >= 0) begin
               r.found = 1'b1;
            end else if (held_count >= MAX_KEYS) begin
               r.status = ST_FULL;
            end else begin
               held_keys[held_count] = k;
               held_count++;
            end
         end
         CMD_REMOVE: begin
            if (hit >= 0) begin
               r.found = 1'b1;
               for (int i = hit; i + 1 < held_count; i++) held_keys[i] = held_keys[i + 1];
               held_count--;
            end
         end
         CMD_LOOKUP: begin
            r.found = (hit >= 0);
         end
         CMD_READ: begin
            if (held_count == 0 || int'(item.position) >= held_count) begin
               r.status = ST_BAD;
            end else begin
               r.key_out = held_keys[held_count - 1 - int'(item.position)];
            end
         end
      endcase
      r.key_count = CNT_OUT_W'(held_count);
      return r;
   endfunction

   function automatic req_type make_item(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                         logic [POS_W-1:0] pos);
      req_type item;
      item.cmd      = cmd;
      item.key_in   = key;
      item.position = pos;
      return item;
   endfunction

   // Mostly keys that are held or from the phase's pool, sometimes a fresh one.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60 && held_count > 0) return held_keys[$urandom_range(held_count - 1)];
      if (roll < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return {$urandom, $urandom};
   endfunction

   // When keys are held, half of the positions are drawn from the held range.
   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(1) == 0 && held_count > 0) return POS_W'($urandom_range(held_count - 1));
      return POS_W'($urandom_range(63));
   endfunction

   function automatic void refill_pool();
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
   endfunction

   // Present one item and hold it until it is taken. Returns at the edge of
   // acceptance with valid still high, so a following item goes straight on.
   task automatic send_item(req_type item);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted_rsp.push_back(predict_table(item));
   endtask

   // One random command, drawn by the given weights; the rest are reads.
   task automatic send_random_item(int w_insert, int w_remove, int w_lookup);
      int         roll;
      logic [1:0] cmd;
      roll = $urandom_range(99);
      if (roll < w_insert) cmd = CMD_INSERT;
      else if (roll < w_insert + w_remove) cmd = CMD_REMOVE;
      else if (roll < w_insert + w_remove + w_lookup) cmd = CMD_LOOKUP;
      else cmd = CMD_READ;
      send_item(make_item(cmd, pick_key(), pick_position()));
   endtask

   // Empty-table replies, duplicates, absent keys, reads at and past the
   // count, and removal from the middle and both ends of the list.
   task automatic test_directed_cases();
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_top;
      key_a   = 64'h0123_4567_89ab_cdef;
      key_top = 64'h8000_0000_0000_0001;
      send_item(make_item(CMD_READ,   '0,      6'd0));
      send_item(make_item(CMD_REMOVE, key_a,   6'd0));
      send_item(make_item(CMD_LOOKUP, key_a,   6'd63));
      send_item(make_item(CMD_INSERT, '0,      6'd0));
      send_item(make_item(CMD_INSERT, '1,      6'd63));
      send_item(make_item(CMD_INSERT, key_top, 6'd0));
      send_item(make_item(CMD_INSERT, '1,      6'd0));
      send_item(make_item(CMD_LOOKUP, '1,      6'd0));
      send_item(make_item(CMD_LOOKUP, key_a,   6'd0));
      send_item(make_item(CMD_READ,   '1,      6'd0));
      send_item(make_item(CMD_READ,   '0,      6'd1));
      send_item(make_item(CMD_READ,   '0,      6'd2));
      send_item(make_item(CMD_READ,   '0,      6'd3));
      send_item(make_item(CMD_READ,   '0,      6'd63));
      send_item(make_item(CMD_REMOVE, '1,      6'd0));
      send_item(make_item(CMD_READ,   '0,      6'd0));
      send_item(make_item(CMD_READ,   '0,      6'd1));
      send_item(make_item(CMD_REMOVE, key_a,   6'd0));
      send_item(make_item(CMD_REMOVE, key_top, 6'd0));
      send_item(make_item(CMD_REMOVE, '0,      6'd0));
      send_item(make_item(CMD_READ,   '0,      6'd0));
      send_item(make_item(CMD_INSERT, key_a,   6'd0));
      send_item(make_item(CMD_READ,   '0,      6'd0));
      send_item(make_item(CMD_REMOVE, key_a,   6'd63));
   endtask

   // Insert-heavy traffic over a pool larger than the table, so the table
   // fills and then refuses absent keys.
   task automatic test_fill_to_full();
      refill_pool();
      repeat (450) send_random_item(60, 10, 15);
   endtask

   // Remove-heavy traffic that empties the table through the compacting shift.
   task automatic test_drain_to_empty();
      repeat (300) send_random_item(10, 60, 15);
   endtask

   // Balanced traffic over a fresh pool, with a stretch of no idling.
   task automatic test_mixed_traffic();
      refill_pool();
      for (int n = 0; n < 900; n++) begin
         no_idle = (n >= 300 && n < 500);
         send_random_item(35, 25, 20);
      end
      no_idle = 1'b0;
   endtask

   // The result side stalls at random, except during the quiet stretch.
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 9);
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_rsp.size() == 0) begin
            $error("result with no prediction waiting: %h", rsp_data);
            failures++;
         end else begin
            want = predicted_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               failures++;
            end
            if (rsp_data.key_out !== want.key_out) begin
               $error("key_out: expected %h, got %h", want.key_out, rsp_data.key_out);
               failures++;
            end
            if (rsp_data.key_count !== want.key_count) begin
               $error("key_count: expected %0d, got %0d", want.key_count,
                      rsp_data.key_count);
               failures++;
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_fill_to_full();
      test_drain_to_empty();
      test_mixed_traffic();
      req_valid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
